// ----- rtl/core/dhs_pkg.sv -----
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared types and constants for the double-hashing DNA word set.
// ----------------------------------------------------------------------------
`default_nettype none

package dhs_pkg;

  // Field widths
  localparam int OPCODE_W = 1;
  localparam int LEN_W    = 4;
  localparam int LETTER_W = 24;
  localparam int STATUS_W = 2;

  // Key encoding: base 5, digits 1..4, first letter least significant
  localparam int KEY_W        = 28;
  localparam int MAX_LETTERS  = 12;
  localparam int HALF_LETTERS = 6;
  localparam int DIGIT_W      = 3;
  localparam int HALF_W       = 14;
  localparam logic [KEY_W-1:0] HALF_SCALE = KEY_W'(15625);  // 5^6

  localparam logic [HALF_W-1:0] POW5 [HALF_LETTERS] = '{
    HALF_W'(1), HALF_W'(5), HALF_W'(25), HALF_W'(125), HALF_W'(625), HALF_W'(3125)
  };

  localparam int TABLE_SIZE_DEF = 1021;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PS_CLEAR,
    PS_IDLE,
    PS_WAIT,
    PS_CHECK
  } probe_state_t;

  // Hash unit result, qualified by valid
  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [KEY_W-1:0] key;
  } hash_ctl_t;

  // Base-5 digit of letter idx, zero past the word's end
  function automatic logic [DIGIT_W-1:0] letter_digit(
    input logic [LETTER_W-1:0] letters,
    input logic [LEN_W-1:0]    len,
    input int                  idx
  );
    logic [1:0] code;
    code = letters[2*idx +: 2];
    if (LEN_W'(idx) < len) begin
      return {1'b0, code} + DIGIT_W'(1);
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dhs_ram.sv -----
// ----------------------------------------------------------------------------
// dhs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dhs_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 1021,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dhs_hash.sv -----
// ----------------------------------------------------------------------------
// dhs_hash
// Word-to-key encoder and home slot / stride unit, five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dhs_hash #(
  parameter int TABLE_SIZE = dhs_pkg::TABLE_SIZE_DEF,
  localparam int IDX_W = $clog2(TABLE_SIZE)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dhs_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic [dhs_pkg::LEN_W-1:0]     word_length,
  input  wire logic [dhs_pkg::LETTER_W-1:0]  letters,
  output dhs_pkg::hash_ctl_t                 res,
  output logic      [IDX_W-1:0]              home,
  output logic      [IDX_W-1:0]              stride
);

  localparam int KW = dhs_pkg::KEY_W;
  localparam int HW = dhs_pkg::HALF_W;
  localparam int HL = dhs_pkg::HALF_LETTERS;
  localparam int RW = IDX_W + 1;
  // Reciprocals for key mod N and key mod (N-1); estimate is off by at most one
  localparam logic [KW-1:0] RECIP_N  = KW'((64'd1 << KW) / TABLE_SIZE);
  localparam logic [KW-1:0] RECIP_N1 = KW'((64'd1 << KW) / (TABLE_SIZE - 1));
  localparam logic [IDX_W-1:0] SIZE_N  = IDX_W'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] SIZE_N1 = IDX_W'(TABLE_SIZE - 1);

  logic [4:0]               vld;
  dhs_pkg::op_t             op0, op1, op2, op3, op4;

  // stage 0: two half sums
  logic [dhs_pkg::LEN_W-1:0] len_sat;
  logic [HW-1:0]             lo_sum, hi_sum;
  logic [HW-1:0]             lo, hi;
  // stage 1: key
  logic [KW-1:0]             key1, key2, key3, key4;
  // stage 2: quotient estimates
  logic [2*KW-1:0]           prod_n, prod_n1;
  logic [KW-1:0]             q_n, q_n1;
  // stage 3: partial remainders in [0, 2N)
  logic [KW+IDX_W-1:0]       back_n, back_n1;
  logic [KW-1:0]             diff_n, diff_n1;
  logic [RW-1:0]             r_n, r_n1;

  always_comb begin
    len_sat = word_length;
    if (word_length > dhs_pkg::LEN_W'(dhs_pkg::MAX_LETTERS)) begin
      len_sat = dhs_pkg::LEN_W'(dhs_pkg::MAX_LETTERS);
    end
    lo_sum = '0;
    hi_sum = '0;
    for (int i = 0; i < HL; i++) begin
      lo_sum = lo_sum + HW'(dhs_pkg::letter_digit(letters, len_sat, i)) * dhs_pkg::POW5[i];
      hi_sum = hi_sum + HW'(dhs_pkg::letter_digit(letters, len_sat, i + HL))
                        * dhs_pkg::POW5[i];
    end
  end

  always_comb begin
    prod_n  = {{KW{1'b0}}, key2} * {{KW{1'b0}}, RECIP_N};
    prod_n1 = {{KW{1'b0}}, key2} * {{KW{1'b0}}, RECIP_N1};
    back_n  = {{IDX_W{1'b0}}, q_n} * {{KW{1'b0}}, SIZE_N};
    back_n1 = {{IDX_W{1'b0}}, q_n1} * {{KW{1'b0}}, SIZE_N1};
    diff_n  = key3 - back_n[KW-1:0];
    diff_n1 = key3 - back_n1[KW-1:0];
  end

  // final correction straight off r_n so home and stride line up with res
  always_comb begin
    if (r_n >= RW'(TABLE_SIZE)) begin
      home = IDX_W'(r_n - RW'(TABLE_SIZE));
    end else begin
      home = r_n[IDX_W-1:0];
    end
    // stride is 1 + key mod (N-1), always below N
    if (r_n1 >= RW'(TABLE_SIZE - 1)) begin
      stride = IDX_W'(r_n1 - RW'(TABLE_SIZE - 1) + RW'(1));
    end else begin
      stride = IDX_W'(r_n1 + RW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op0 <= dhs_pkg::op_t'(opcode);
      lo  <= lo_sum;
      hi  <= hi_sum;
    end
    op1  <= op0;
    key1 <= KW'(hi) * dhs_pkg::HALF_SCALE + KW'(lo);
    op2  <= op1;
    key2 <= key1;
    q_n  <= prod_n[2*KW-1:KW];
    q_n1 <= prod_n1[2*KW-1:KW];
    op3  <= op2;
    key3 <= key2;
    r_n  <= diff_n[RW-1:0];
    r_n1 <= diff_n1[RW-1:0];
    op4  <= op3;
    key4 <= key3;
  end

  assign res.valid = vld[4];
  assign res.op    = op4;
  assign res.key   = key4;

endmodule

`default_nettype wire

// ----- rtl/core/dhs_probe.sv -----
// ----------------------------------------------------------------------------
// dhs_probe
// Table clear sequencer and probe engine around the slot key memory.
// ----------------------------------------------------------------------------
`default_nettype none

module dhs_probe #(
  parameter int TABLE_SIZE = dhs_pkg::TABLE_SIZE_DEF,
  localparam int IDX_W = $clog2(TABLE_SIZE)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire dhs_pkg::hash_ctl_t            hres,
  input  wire logic [IDX_W-1:0]              home,
  input  wire logic [IDX_W-1:0]              stride_in,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [dhs_pkg::STATUS_W-1:0]  status
);

  localparam int KW = dhs_pkg::KEY_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  dhs_pkg::probe_state_t state, state_next;

  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] pos, stride, cnt;
  logic [KW-1:0]    key;
  dhs_pkg::op_t     op;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [KW-1:0]    wdata, held;

  logic             hit, empty, last, done, out_free, finish;
  logic [IDX_W:0]   pos_sum;
  logic [IDX_W-1:0] pos_next;
  dhs_pkg::status_t result;

  dhs_ram #(
    .WIDTH (KW),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (held)
  );

  always_comb begin
    hit      = (held == key);
    empty    = (held == '0);
    last     = (cnt == LAST_IDX);
    done     = hit | empty | last;
    out_free = ~out_valid | ~out_stall;
    finish   = (state == dhs_pkg::PS_CHECK) & done & out_free;
    pos_sum  = {1'b0, pos} + {1'b0, stride};
    pos_next = pos_sum[IDX_W-1:0];
    if (pos_sum >= (IDX_W+1)'(TABLE_SIZE)) begin
      pos_next = IDX_W'(pos_sum - (IDX_W+1)'(TABLE_SIZE));
    end
    if (hit) begin
      result = dhs_pkg::ST_PRESENT;
    end else if (empty) begin
      result = dhs_pkg::ST_NEW;
    end else begin
      result = dhs_pkg::ST_FULL;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = pos;
    wdata      = key;
    raddr      = pos;
    case (state)
      dhs_pkg::PS_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = '0;
        if (clr_idx == LAST_IDX) begin
          state_next = dhs_pkg::PS_IDLE;
        end
      end
      dhs_pkg::PS_IDLE: begin
        if (start) begin
          state_next = dhs_pkg::PS_WAIT;
        end
      end
      dhs_pkg::PS_WAIT: begin
        raddr = home;
        if (hres.valid) begin
          state_next = dhs_pkg::PS_CHECK;
        end
      end
      dhs_pkg::PS_CHECK: begin
        if (!done) begin
          // read ahead so the next probe's key lands in the next cycle
          raddr = pos_next;
        end else if (finish) begin
          we         = ~hit & empty & (op == dhs_pkg::OP_INSERT);
          state_next = dhs_pkg::PS_IDLE;
        end
      end
      default: begin
        state_next = dhs_pkg::PS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dhs_pkg::PS_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dhs_pkg::PS_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == dhs_pkg::PS_WAIT && hres.valid) begin
      pos    <= home;
      stride <= stride_in;
      key    <= hres.key;
      op     <= hres.op;
      cnt    <= '0;
    end else if (state == dhs_pkg::PS_CHECK && !done) begin
      pos <= pos_next;
      cnt <= cnt + IDX_W'(1);
    end
    if (finish) begin
      status <= result;
    end
  end

  assign busy = (state != dhs_pkg::PS_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/double_hash_set_insert_find_top.sv -----
// ----------------------------------------------------------------------------
// double_hash_set_insert_find_top
// DNA word set: open-addressed hash table with double hashing.
// ----------------------------------------------------------------------------
// Result: valid once the hash pipeline and P probes are through, P = probes
//   (1..TABLE_SIZE), one probe per cycle against the single table memory.
// Input: the next input is taken the cycle after the result is produced,
//   even if that result is still stalled.
// Reset: a clearing pass writes every slot to empty with in_stall high,
//   then the block goes idle.
`default_nettype none

module double_hash_set_insert_find_top #(
  parameter int TABLE_SIZE = dhs_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dhs_pkg::OPCODE_W-1:0]  opcode,
  input  wire logic [dhs_pkg::LEN_W-1:0]     word_length,
  input  wire logic [dhs_pkg::LETTER_W-1:0]  letters,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [dhs_pkg::STATUS_W-1:0]  status
);

  localparam int IDX_W = $clog2(TABLE_SIZE);

  logic               busy, start;
  dhs_pkg::hash_ctl_t hres;
  logic [IDX_W-1:0]   home, stride;

  assign in_stall = busy;
  assign start    = in_valid & ~busy;

  dhs_hash #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_hash (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .opcode      (opcode),
    .word_length (word_length),
    .letters     (letters),
    .res         (hres),
    .home        (home),
    .stride      (stride)
  );

  dhs_probe #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_probe (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .hres      (hres),
    .home      (home),
    .stride_in (stride),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dhs_checker.sv -----
// ----------------------------------------------------------------------------
// dhs_checker
// Port-level checks for the DNA word set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dhs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] status
);

  // block is busy right after reset (clear pass) and after taking a transaction
  a_stall_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("in_stall low right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous transaction still in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_status_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(status))
    else $error("status changed while stalled");

endmodule

bind double_hash_set_insert_find_top dhs_checker u_dhs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status)
);

`default_nettype wire
